// File: rtl/sahc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sahc_pkg
// Shared sizes, codes and types of the set-associative hit classifier.
// ---------------------------------------------------------------------------
package sahc_pkg;

   // cache geometry
   localparam int SETS     = 1024;
   localparam int SET_W    = $clog2(SETS);
   localparam int MAX_WAYS = 8;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int FILL_W   = $clog2(MAX_WAYS + 1);
   localparam int TAG_W    = 30;

   // register and result field widths
   localparam int WAYS_CFG_W  = 4;
   localparam int BLOCK_CFG_W = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int OUTCOME_W   = 2;
   localparam int CNT_W       = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 2'd1;

   // register reset values
   localparam logic [WAYS_CFG_W-1:0]  WAYS_RESET  = 4'd8;
   localparam logic [BLOCK_CFG_W-1:0] BLOCK_RESET = 9'd16;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_HIT      = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_FILL     = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_CONFLICT = 2'd2;

   // one set of tags read as a single wide word
   typedef logic [MAX_WAYS-1:0][TAG_W-1:0] row_type;

   // result of the parallel tag compare
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
   } match_type;

endpackage
`default_nettype wire

// File: rtl/set_assoc_cache_hit_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// set_assoc_cache_hit_classifier
// Tag lookup of a set-associative cache with hit / compulsory / conflict
// classification and saturating running totals.
//
//   channel   ports                         handshake
//   access    req_set_index, req_tag        start && !busy
//   result    rsp_outcome .. rsp_cycle_total rsp_valid, one cycle
//   config    csr_index, csr_wdata          csr_we
//
// The set row and its fill count of an access are read from the synchronous
// memories when it is accepted, then compared and written back in ST_LOOK.
// busy holds off the next access until the write-back is done. The result
// strobe comes in the cycle after the write-back and is never stalled.
// After reset the fill-count memory is cleared one set a cycle with busy
// high; configuration writes are taken during that pass.
// ---------------------------------------------------------------------------
module set_assoc_cache_hit_classifier (
   input  var logic                                 clock,
   input  var logic                                 reset,
   // access
   input  var logic                                 start,
   output var logic                                 busy,
   input  var logic [sahc_pkg::SET_W-1:0]           req_set_index,
   input  var logic [sahc_pkg::TAG_W-1:0]           req_tag,
   // result
   output var logic                                 rsp_valid,
   output var logic [sahc_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output var logic [sahc_pkg::WAY_W-1:0]           rsp_way,
   output var logic [sahc_pkg::CNT_W-1:0]           rsp_hit_total,
   output var logic [sahc_pkg::CNT_W-1:0]           rsp_compulsory_total,
   output var logic [sahc_pkg::CNT_W-1:0]           rsp_conflict_total,
   output var logic [sahc_pkg::CNT_W-1:0]           rsp_cycle_total,
   // configuration
   input  var logic                                 csr_we,
   input  var logic [sahc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  var logic [sahc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sahc_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   // memories
   row_type                tag_mem  [SETS];
   logic [FILL_W-1:0]      fill_mem [SETS];

   logic [1:0]             state_ff, state_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   logic [WAYS_CFG_W-1:0]  ways_ff;
   logic [BLOCK_CFG_W-1:0] block_ff;

   row_type                row_rd_ff;
   logic [FILL_W-1:0]      fill_rd_ff;
   logic [SET_W-1:0]       set_ff;
   logic [TAG_W-1:0]       tag_ff;

   logic [CNT_W-1:0]       hit_ff, hit_in;
   logic [CNT_W-1:0]       comp_ff, comp_in;
   logic [CNT_W-1:0]       conf_ff, conf_in;
   logic [CNT_W-1:0]       cyc_ff, cyc_in;
   logic                   valid_ff;
   logic [OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic [WAY_W-1:0]       way_ff, way_in;

   logic                   accept;
   logic                   look;
   logic [FILL_W-1:0]      filled;
   logic [FILL_W-1:0]      limit;
   logic                   do_fill;
   row_type                row_new;
   match_type              match;
   logic [BLOCK_CFG_W-1:0] miss_cost;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign look   = (state_ff == ST_LOOK);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff  <= WAYS_RESET;
         block_ff <= BLOCK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAYS_IN_USE: ways_ff  <= csr_wdata[WAYS_CFG_W-1:0];
            CSR_BLOCK_BYTES: block_ff <= csr_wdata[BLOCK_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // access capture
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_set_index;
         tag_ff <= req_tag;
      end
   end

   // tag row memory, read on accept, written back on a fill
   always_ff @(posedge clock) begin
      if (accept) begin
         row_rd_ff <= tag_mem[req_set_index];
      end
      if (look && do_fill) begin
         tag_mem[set_ff] <= row_new;
      end
   end

   // fill count memory, cleared after reset
   always_ff @(posedge clock) begin
      if (accept) begin
         fill_rd_ff <= fill_mem[req_set_index];
      end
      if (state_ff == ST_CLEAR) begin
         fill_mem[clr_ff] <= '0;
      end else if (look && do_fill) begin
         fill_mem[set_ff] <= filled + 1'b1;
      end
   end

   // clamp fill count and associativity to the array
   assign filled = (fill_rd_ff > FILL_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : fill_rd_ff;
   assign limit  = (ways_ff > WAYS_CFG_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS)
                                                    : FILL_W'(ways_ff);

   sahc_way_match u_match (
      .row    (row_rd_ff),
      .tag    (tag_ff),
      .filled (filled),
      .match  (match)
   );

   assign do_fill   = !match.hit && (filled < limit);
   assign miss_cost = {block_ff[BLOCK_CFG_W-1:2], 2'b00};

   // new row with the tag placed in the next free way
   always_comb begin
      row_new = row_rd_ff;
      row_new[filled[WAY_W-1:0]] = tag_ff;
   end

   // classification and saturating totals
   always_comb begin
      logic [CNT_W:0] sum;
      hit_in     = hit_ff;
      comp_in    = comp_ff;
      conf_in    = conf_ff;
      cyc_in     = cyc_ff;
      outcome_in = OUT_CONFLICT;
      way_in     = '0;
      sum        = '0;
      if (match.hit) begin
         outcome_in = OUT_HIT;
         way_in     = match.way;
         hit_in     = (&hit_ff) ? hit_ff : hit_ff + 1'b1;
         cyc_in     = (&cyc_ff) ? cyc_ff : cyc_ff + 1'b1;
      end else if (do_fill) begin
         outcome_in = OUT_FILL;
         way_in     = filled[WAY_W-1:0];
         comp_in    = (&comp_ff) ? comp_ff : comp_ff + 1'b1;
         sum        = {1'b0, cyc_ff} + (CNT_W + 1)'(miss_cost);
         cyc_in     = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      end else begin
         conf_in    = (&conf_ff) ? conf_ff : conf_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= '0;
         comp_ff  <= '0;
         conf_ff  <= '0;
         cyc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= look;
         if (look) begin
            hit_ff  <= hit_in;
            comp_ff <= comp_in;
            conf_ff <= conf_in;
            cyc_ff  <= cyc_in;
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (look) begin
         outcome_ff <= outcome_in;
         way_ff     <= way_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_way              = way_ff;
   assign rsp_hit_total        = hit_ff;
   assign rsp_compulsory_total = comp_ff;
   assign rsp_conflict_total   = conf_ff;
   assign rsp_cycle_total      = cyc_ff;

endmodule
`default_nettype wire

// File: rtl/sahc_way_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sahc_way_match
// Compares the access tag against every filled way of one set row and
// picks the lowest matching way.
// ---------------------------------------------------------------------------
module sahc_way_match (
   input  var sahc_pkg::row_type                  row,
   input  var logic [sahc_pkg::TAG_W-1:0]         tag,
   input  var logic [sahc_pkg::FILL_W-1:0]        filled,
   output var sahc_pkg::match_type                match
);
   import sahc_pkg::*;

   logic [MAX_WAYS-1:0] eq;

   // per-way compare, only ways below the fill count take part
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         eq[w] = (row[w] == tag) && (FILL_W'(w) < filled);
      end
   end

   // lowest matching way wins
   always_comb begin
      match.hit = |eq;
      match.way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (eq[w]) begin
            match.way = WAY_W'(w);
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/sahc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sahc_checker
// Port-level checks of the hit classifier, bound to the top level.
// ---------------------------------------------------------------------------
module sahc_checker (
   input  var logic                               clock,
   input  var logic                               reset,
   input  var logic                               start,
   input  var logic                               busy,
   input  var logic                               rsp_valid,
   input  var logic [sahc_pkg::OUTCOME_W-1:0]     rsp_outcome,
   input  var logic [sahc_pkg::WAY_W-1:0]         rsp_way,
   input  var logic [sahc_pkg::CNT_W-1:0]         rsp_hit_total
);
   import sahc_pkg::*;

   // an accepted word is under way in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("access accepted but block not busy");

   // every accepted word gets its result strobe once the look state has passed
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing after access");

   // the strobe lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // a conflict miss reports way zero
   a_conflict_way: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_CONFLICT) |-> (rsp_way == '0))
      else $error("conflict miss with nonzero way");

   // the hit total never falls between results
   a_hit_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid, 2) && !$past(reset, 2)) |->
         (rsp_hit_total >= $past(rsp_hit_total, 2)))
      else $error("hit total decreased");

endmodule

bind set_assoc_cache_hit_classifier sahc_checker u_sahc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_outcome   (rsp_outcome),
   .rsp_way       (rsp_way),
   .rsp_hit_total (rsp_hit_total)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative hit classifier. A directed
// pass walks fills, hits, conflicts and the odd register values; random
// phases then hammer a few hot sets under several cache settings. Every
// result word is checked against an in-bench tag store and running totals.
// ---------------------------------------------------------------------------
module tb_top;
   import sahc_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 60;
   localparam int TAIL_CYCLES  = 8;
   localparam int HOT_COUNT    = 8;

   // register slots past the defined list, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // clock, reset and block inputs
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   start         = 1'b0;
   logic [SET_W-1:0]       req_set_index = '0;
   logic [TAG_W-1:0]       req_tag       = '0;
   logic                   csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   // block outputs
   logic                   busy;
   logic                   rsp_valid;
   logic [OUTCOME_W-1:0]   rsp_outcome;
   logic [WAY_W-1:0]       rsp_way;
   logic [CNT_W-1:0]       rsp_hit_total;
   logic [CNT_W-1:0]       rsp_compulsory_total;
   logic [CNT_W-1:0]       rsp_conflict_total;
   logic [CNT_W-1:0]       rsp_cycle_total;

   int                     sender_idle_pct = 0;
   int                     setting_count   = 0;
   int                     stall_cycles    = 0;
   logic [SET_W-1:0]       hot_sets [HOT_COUNT];

   typedef struct {
      logic [OUTCOME_W-1:0] outcome;
      logic [WAY_W-1:0]     way;
      logic [CNT_W-1:0]     hit_total;
      logic [CNT_W-1:0]     compulsory_total;
      logic [CNT_W-1:0]     conflict_total;
      logic [CNT_W-1:0]     cycle_total;
   } lookup_word_type;

   // tag store, fill levels and totals, plus the words still awaited
   class cache_lookup_scoreboard;
      bit [TAG_W-1:0]       tag_rows [SETS][MAX_WAYS];
      bit [FILL_W-1:0]      fill_level [SETS];
      bit [CNT_W-1:0]       hit_count, fill_count, conflict_count, cycle_count;
      bit [WAYS_CFG_W-1:0]  ways_cfg;
      bit [BLOCK_CFG_W-1:0] block_cfg;
      lookup_word_type      awaited_q [$];
      int                   errors, n_hit, n_fill, n_conflict;

      function new();
         ways_cfg  = WAYS_RESET;
         block_cfg = BLOCK_RESET;
      endfunction

      function bit [CNT_W-1:0] sat_add(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
         bit [CNT_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WAYS_IN_USE: ways_cfg = data[WAYS_CFG_W-1:0];
            CSR_BLOCK_BYTES: block_cfg = data[BLOCK_CFG_W-1:0];
            default: ;
         endcase
      endfunction

      // classify one access and queue the word it should produce
      function void note_access(logic [SET_W-1:0] set_idx, logic [TAG_W-1:0] tag);
         bit [FILL_W-1:0] limit;
         bit [FILL_W-1:0] filled;
         bit              hit;
         lookup_word_type want;
         limit    = (ways_cfg > MAX_WAYS) ? FILL_W'(MAX_WAYS) : FILL_W'(ways_cfg);
         filled   = fill_level[set_idx];
         hit      = 1'b0;
         want.way = '0;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && w < filled && tag_rows[set_idx][w] == tag) begin
               hit      = 1'b1;
               want.way = WAY_W'(w);
            end
         end
         if (hit) begin
            want.outcome = OUT_HIT;
            hit_count    = sat_add(hit_count, CNT_W'(1));
            cycle_count  = sat_add(cycle_count, CNT_W'(1));
         end else if (filled < limit) begin
            // next free way takes the tag, cost is the block size rounded down
            want.outcome                = OUT_FILL;
            want.way                    = filled[WAY_W-1:0];
            tag_rows[set_idx][filled]   = tag;
            fill_level[set_idx]         = filled + 1'b1;
            fill_count                  = sat_add(fill_count, CNT_W'(1));
            cycle_count = sat_add(cycle_count, CNT_W'({block_cfg[BLOCK_CFG_W-1:2], 2'b00}));
         end else begin
            want.outcome   = OUT_CONFLICT;
            conflict_count = sat_add(conflict_count, CNT_W'(1));
         end
         want.hit_total        = hit_count;
         want.compulsory_total = fill_count;
         want.conflict_total   = conflict_count;
         want.cycle_total      = cycle_count;
         awaited_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [CNT_W-1:0] want,
                                  logic [CNT_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
         end
      endfunction

      function void check_result(lookup_word_type got);
         lookup_word_type want;
         if (awaited_q.size() == 0) begin
            errors++;
            $display("%0t: result word with none awaited, outcome %0d way %0d",
                     $time, got.outcome, got.way);
            return;
         end
         want = awaited_q.pop_front();
         compare_field("outcome", CNT_W'(want.outcome), CNT_W'(got.outcome));
         compare_field("way", CNT_W'(want.way), CNT_W'(got.way));
         compare_field("hit_total", want.hit_total, got.hit_total);
         compare_field("compulsory_total", want.compulsory_total, got.compulsory_total);
         compare_field("conflict_total", want.conflict_total, got.conflict_total);
         compare_field("cycle_total", want.cycle_total, got.cycle_total);
         case (want.outcome)
            OUT_HIT:  n_hit++;
            OUT_FILL: n_fill++;
            default:  n_conflict++;
         endcase
      endfunction
   endclass

   cache_lookup_scoreboard lookup_sb = new();

   set_assoc_cache_hit_classifier u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_set_index        (req_set_index),
      .req_tag              (req_tag),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_way              (rsp_way),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_compulsory_total (rsp_compulsory_total),
      .rsp_conflict_total   (rsp_conflict_total),
      .rsp_cycle_total      (rsp_cycle_total),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // accepted access words feed the predictor, result words get checked
   always @(posedge clock) begin
      lookup_word_type seen;
      if (!reset && start && !busy)
         lookup_sb.note_access(req_set_index, req_tag);
      if (!reset && rsp_valid) begin
         seen.outcome          = rsp_outcome;
         seen.way              = rsp_way;
         seen.hit_total        = rsp_hit_total;
         seen.compulsory_total = rsp_compulsory_total;
         seen.conflict_total   = rsp_conflict_total;
         seen.cycle_total      = rsp_cycle_total;
         lookup_sb.check_result(seen);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      lookup_sb.write_register(idx, data);
   endtask

   // one junk write to a spare slot, then both real registers
   task automatic apply_settings(input logic [WAYS_CFG_W-1:0] ways,
                                 input logic [BLOCK_CFG_W-1:0] bytes);
      write_csr(setting_count[0] ? CSR_SPARE_B : CSR_SPARE_A,
                CSR_DATA_W'($urandom_range(511)));
      write_csr(CSR_WAYS_IN_USE, CSR_DATA_W'(ways));
      write_csr(CSR_BLOCK_BYTES, CSR_DATA_W'(bytes));
      csr_we <= 1'b0;
      setting_count++;
   endtask

   // present one access word, returns at the edge that takes it
   task automatic send_access(input logic [SET_W-1:0] set_idx,
                              input logic [TAG_W-1:0] tag);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start         <= 1'b1;
      req_set_index <= set_idx;
      req_tag       <= tag;
      do @(posedge clock); while (busy);
   endtask

   // drop start and let every awaited word come back
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (lookup_sb.awaited_q.size() != 0) @(posedge clock);
   endtask

   // mostly hot sets with reused tags, the rest anywhere
   task automatic random_access();
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      int               filled;
      if ($urandom_range(99) < 75) begin
         set_idx = hot_sets[$urandom_range(HOT_COUNT-1)];
         filled  = lookup_sb.fill_level[set_idx];
         if (filled != 0 && $urandom_range(99) < 55)
            tag = lookup_sb.tag_rows[set_idx][$urandom_range(filled-1)];
         else
            tag = TAG_W'($urandom());
      end else begin
         set_idx = SET_W'($urandom());
         tag     = TAG_W'($urandom());
      end
      send_access(set_idx, tag);
   endtask

   task automatic run_phase(input logic [WAYS_CFG_W-1:0] ways,
                            input logic [BLOCK_CFG_W-1:0] bytes,
                            input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int h = HOT_COUNT / 2; h < HOT_COUNT; h++)
         hot_sets[h] = SET_W'($urandom());
      apply_settings(ways, bytes);
      repeat (PHASE_ITEMS) random_access();
      wait_idle();
   endtask

   initial begin
      hot_sets[0] = '0;
      hot_sets[1] = SET_W'(SETS - 1);
      for (int h = 2; h < HOT_COUNT; h++)
         hot_sets[h] = SET_W'($urandom());
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // three ways, odd block size: fills, hits at both tag extremes, a conflict
      sender_idle_pct = 22;
      apply_settings(4'd3, 9'd7);
      send_access(10'd0, 30'h0000_0000);
      send_access(10'd0, 30'h3FFF_FFFF);
      send_access(10'd0, 30'h0000_0000);
      send_access(10'd0, 30'h3FFF_FFFF);
      send_access(10'd0, 30'h0000_0001);
      send_access(10'd0, 30'h0000_0002);
      send_access(10'd1023, 30'h2AAA_AAAA);
      send_access(10'd1023, 30'h1555_5555);
      send_access(10'd1023, 30'h2AAA_AAAA);
      send_access(10'd0, 30'h0000_0001);
      wait_idle();

      // zero ways: misses all conflict, filled ways still hit, tiny block
      apply_settings(4'd0, 9'd3);
      send_access(10'd512, 30'h0000_0005);
      send_access(10'd0, 30'h0000_0000);
      wait_idle();

      // ways above the array clamp to the maximum, largest block
      apply_settings(4'd15, 9'd511);
      send_access(10'd0, 30'h0000_0002);
      send_access(10'd512, 30'h0000_0005);
      send_access(10'd0, 30'h0000_0002);
      wait_idle();

      // ways lowered under filled sets, zero block size
      apply_settings(4'd1, 9'd0);
      send_access(10'd0, 30'h3FFF_FFFF);
      send_access(10'd0, 30'h0000_0009);
      send_access(10'd341, 30'h0000_0007);
      send_access(10'd341, 30'h0000_0008);
      send_access(10'd341, 30'h0000_0007);
      wait_idle();

      // random phases under varied settings and sender gaps
      run_phase(4'd8, 9'd16, 22);
      run_phase(4'd1, 9'd4, 22);
      run_phase(4'd9, 9'd256, 22);
      run_phase(4'd2, 9'd255, 62);
      run_phase(4'd15, 9'd511, 62);
      run_phase(4'd0, 9'd5, 62);
      run_phase(4'd5, 9'd100, 0);
      run_phase(4'd8, 9'd2, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (lookup_sb.awaited_q.size() != 0) begin
         lookup_sb.errors++;
         $display("%0t: %0d result words never arrived", $time,
                  lookup_sb.awaited_q.size());
      end

      $display("checked %0d hits, %0d compulsory fills, %0d conflict misses",
               lookup_sb.n_hit, lookup_sb.n_fill, lookup_sb.n_conflict);
      $display("over %0d cache settings, modeled cycle total %0d",
               setting_count, lookup_sb.cycle_count);
      if (lookup_sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: set_assoc_cache_hit_classifier.f
rtl/sahc_pkg.sv
rtl/sahc_way_match.sv
rtl/set_assoc_cache_hit_classifier.sv
rtl/sahc_checker.sv
tb/tb_top.sv
